// ----- sv/e2c_pkg.sv -----
// package for the epoch seconds to calendar date converter
// widths, constants, result and subtractor types, month length table
// no dependencies
`timescale 1ns / 1ps

package e2c_pkg;

    localparam int unsigned EpochW  = 32;
    localparam int unsigned OffW    = 5;
    localparam int unsigned SumW    = 34;
    localparam int unsigned TimeW   = 33;
    localparam int unsigned DayW    = 16;
    localparam int unsigned YearW   = 12;
    localparam int unsigned MonthW  = 4;
    localparam int unsigned MdayW   = 5;
    localparam int unsigned HourW   = 5;
    localparam int unsigned MinW    = 6;
    localparam int unsigned SecW    = 6;
    localparam int unsigned LenW    = 9;
    localparam int unsigned RemW    = 6;
    localparam int unsigned CntW    = 6;
    localparam int unsigned Mod100W = 7;
    localparam int unsigned Mod400W = 9;

    localparam logic signed [SumW-1:0] SecPerHour = SumW'(3600);
    localparam logic [RemW-1:0]        DivSixty   = RemW'(60);
    localparam logic [RemW-1:0]        DivHours   = RemW'(24);
    localparam logic [YearW-1:0]       BaseYear   = YearW'(1970);
    localparam logic [Mod100W-1:0]     BaseMod100 = Mod100W'(70);
    localparam logic [Mod400W-1:0]     BaseMod400 = Mod400W'(370);
    localparam logic [Mod100W-1:0]     Mod100Last = Mod100W'(99);
    localparam logic [Mod400W-1:0]     Mod400Last = Mod400W'(399);
    localparam logic [LenW-1:0]        DaysLeap   = LenW'(366);
    localparam logic [LenW-1:0]        DaysCommon = LenW'(365);
    localparam logic [MonthW-1:0]      MonthJan   = MonthW'(1);
    localparam logic [MonthW-1:0]      MonthFeb   = MonthW'(2);
    localparam logic [MonthW-1:0]      MonthDec   = MonthW'(12);
    localparam logic [CntW-1:0]        DivSteps   = CntW'(TimeW - 1);

    typedef struct packed {
        logic            ge;
        logic [DayW-1:0] diff;
    } t_sub_res;

    typedef struct packed {
        logic [YearW-1:0]  year_value;
        logic [MonthW-1:0] month_value;
        logic [MdayW-1:0]  day_value;
        logic [HourW-1:0]  hour_value;
        logic [MinW-1:0]   minute_value;
        logic [SecW-1:0]   second_value;
    } t_result;

    function automatic logic [LenW-1:0] month_days(input logic [MonthW-1:0] m,
                                                   input logic leap);
        logic [LenW-1:0] d;
        begin
            case (m)
                4'd4, 4'd6, 4'd9, 4'd11: d = LenW'(30);
                MonthFeb:                d = leap ? LenW'(29) : LenW'(28);
                default:                 d = LenW'(31);
            endcase
            return d;
        end
    endfunction

endpackage

// ----- sv/e2c_if.sv -----
// channel interfaces: seconds input, date result, offset configuration
// depends on e2c_pkg
`timescale 1ns / 1ps

interface e2c_in_if;
    logic                          valid;
    logic                          ready;
    logic [e2c_pkg::EpochW-1:0]    epoch_seconds;
    modport source (output valid, output epoch_seconds, input ready);
    modport sink   (input valid, input epoch_seconds, output ready);
endinterface

interface e2c_out_if;
    logic                          valid;
    logic                          ready;
    logic [e2c_pkg::YearW-1:0]     year_value;
    logic [e2c_pkg::MonthW-1:0]    month_value;
    logic [e2c_pkg::MdayW-1:0]     day_value;
    logic [e2c_pkg::HourW-1:0]     hour_value;
    logic [e2c_pkg::MinW-1:0]      minute_value;
    logic [e2c_pkg::SecW-1:0]      second_value;
    modport source (output valid, output year_value, output month_value,
                    output day_value, output hour_value, output minute_value,
                    output second_value, input ready);
    modport sink   (input valid, input year_value, input month_value,
                    input day_value, input hour_value, input minute_value,
                    input second_value, output ready);
endinterface

interface e2c_cfg_if;
    logic                          valid;
    logic                          ready;
    logic signed [e2c_pkg::OffW-1:0] utc_offset_hours;
    modport source (output valid, output utc_offset_hours, input ready);
    modport sink   (input valid, input utc_offset_hours, output ready);
endinterface

// ----- sv/e2c_sub_unit.sv -----
// shared compare and subtract unit used by the division, year and month steps of the conversion
// depends on e2c_pkg
`timescale 1ns / 1ps

module e2c_sub_unit (
    input  logic [e2c_pkg::DayW-1:0] i_a,
    input  logic [e2c_pkg::DayW-1:0] i_b,
    output e2c_pkg::t_sub_res        o_res
);

    logic [e2c_pkg::DayW:0] w_diff;

    // borrow out of the extended subtract gives a < b
    assign w_diff     = {1'b0, i_a} - {1'b0, i_b};
    assign o_res.ge   = ~w_diff[e2c_pkg::DayW];
    assign o_res.diff = w_diff[e2c_pkg::DayW-1:0];

endmodule

// ----- sv/e2c_seq.sv -----
// sequencer: restoring division by 60, 60, 24, then year and month walks
// depends on e2c_pkg and e2c_sub_unit
`timescale 1ns / 1ps

module e2c_seq (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [e2c_pkg::EpochW-1:0]        i_epoch,
    input  logic signed [e2c_pkg::OffW-1:0]   i_offset,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output e2c_pkg::t_result                  o_result
);

    typedef enum logic [2:0] {S_IDLE, S_DIV, S_YEAR, S_MONTH, S_DONE} t_state;
    typedef enum logic [1:0] {PH_SEC, PH_MIN, PH_HR} t_phase;

    t_state                        r_state, n_state;
    t_phase                        r_phase, n_phase;
    logic [e2c_pkg::CntW-1:0]      r_cnt, n_cnt;
    logic [e2c_pkg::TimeW-1:0]     r_dvd, n_dvd;
    logic [e2c_pkg::RemW-1:0]      r_rem, n_rem;
    logic [e2c_pkg::SecW-1:0]      r_sec, n_sec;
    logic [e2c_pkg::MinW-1:0]      r_min, n_min;
    logic [e2c_pkg::HourW-1:0]     r_hr, n_hr;
    logic [e2c_pkg::DayW-1:0]      r_days, n_days;
    logic [e2c_pkg::YearW-1:0]     r_year, n_year;
    logic [e2c_pkg::Mod100W-1:0]   r_m100, n_m100;
    logic [e2c_pkg::Mod400W-1:0]   r_m400, n_m400;
    logic [e2c_pkg::MonthW-1:0]    r_month, n_month;
    e2c_pkg::t_result              r_out, n_out;
    logic                          r_out_valid, n_out_valid;

    logic signed [e2c_pkg::SumW-1:0] w_off_ext, w_off_sec, w_sum;
    logic [e2c_pkg::RemW:0]          w_trial;
    logic [e2c_pkg::RemW-1:0]        w_divisor;
    logic [e2c_pkg::DayW-1:0]        w_a, w_b;
    logic                            w_leap;
    logic                            w_out_free;
    e2c_pkg::t_sub_res               w_res;

    e2c_sub_unit u_sub (
        .i_a   (w_a),
        .i_b   (w_b),
        .o_res (w_res)
    );

    assign w_off_ext = {{(e2c_pkg::SumW-e2c_pkg::OffW){i_offset[e2c_pkg::OffW-1]}}, i_offset};
    assign w_off_sec = w_off_ext * e2c_pkg::SecPerHour;
    assign w_sum     = $signed({2'b00, i_epoch}) + w_off_sec;

    assign w_trial    = {r_rem, r_dvd[e2c_pkg::TimeW-1]};
    assign w_divisor  = (r_phase == PH_HR) ? e2c_pkg::DivHours : e2c_pkg::DivSixty;
    assign w_leap     = (r_m400 == '0) || ((r_m100 != '0) && (r_year[1:0] == 2'b00));
    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        w_a = '0;
        w_b = '0;
        case (r_state)
            S_DIV: begin
                w_a = e2c_pkg::DayW'(w_trial);
                w_b = e2c_pkg::DayW'(w_divisor);
            end
            S_YEAR: begin
                w_a = r_days;
                w_b = e2c_pkg::DayW'(w_leap ? e2c_pkg::DaysLeap : e2c_pkg::DaysCommon);
            end
            S_MONTH: begin
                w_a = r_days;
                w_b = e2c_pkg::DayW'(e2c_pkg::month_days(r_month, w_leap));
            end
            default: begin
                w_a = '0;
                w_b = '0;
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_cnt       = r_cnt;
        n_dvd       = r_dvd;
        n_rem       = r_rem;
        n_sec       = r_sec;
        n_min       = r_min;
        n_hr        = r_hr;
        n_days      = r_days;
        n_year      = r_year;
        n_m100      = r_m100;
        n_m400      = r_m400;
        n_month     = r_month;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    // negative local time clamps to the epoch
                    n_dvd   = w_sum[e2c_pkg::SumW-1] ? '0 : w_sum[e2c_pkg::TimeW-1:0];
                    n_rem   = '0;
                    n_cnt   = '0;
                    n_phase = PH_SEC;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_dvd = {r_dvd[e2c_pkg::TimeW-2:0], w_res.ge};
                n_rem = w_res.ge ? w_res.diff[e2c_pkg::RemW-1:0]
                                 : w_trial[e2c_pkg::RemW-1:0];
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == e2c_pkg::DivSteps) begin
                    n_cnt = '0;
                    unique case (r_phase)
                        PH_SEC: begin
                            n_sec   = n_rem;
                            n_phase = PH_MIN;
                        end
                        PH_MIN: begin
                            n_min   = n_rem;
                            n_phase = PH_HR;
                        end
                        PH_HR: begin
                            n_hr    = n_rem[e2c_pkg::HourW-1:0];
                            n_days  = n_dvd[e2c_pkg::DayW-1:0];
                            n_year  = e2c_pkg::BaseYear;
                            n_m100  = e2c_pkg::BaseMod100;
                            n_m400  = e2c_pkg::BaseMod400;
                            n_state = S_YEAR;
                        end
                        default: n_phase = PH_SEC;
                    endcase
                    // next division starts from an empty remainder
                    n_rem = '0;
                end
            end
            S_YEAR: begin
                if (w_res.ge) begin
                    n_days = w_res.diff;
                    n_year = r_year + 1'b1;
                    n_m100 = (r_m100 == e2c_pkg::Mod100Last) ? '0 : r_m100 + 1'b1;
                    n_m400 = (r_m400 == e2c_pkg::Mod400Last) ? '0 : r_m400 + 1'b1;
                end else begin
                    n_month = e2c_pkg::MonthJan;
                    n_state = S_MONTH;
                end
            end
            S_MONTH: begin
                if (r_month != e2c_pkg::MonthDec && w_res.ge) begin
                    n_days  = w_res.diff;
                    n_month = r_month + 1'b1;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // hold the finished item until the result register frees up
                if (w_out_free) begin
                    n_out.year_value   = r_year;
                    n_out.month_value  = r_month;
                    n_out.day_value    = r_days[e2c_pkg::MdayW-1:0] + 1'b1;
                    n_out.hour_value   = r_hr;
                    n_out.minute_value = r_min;
                    n_out.second_value = r_sec;
                    n_out_valid        = 1'b1;
                    n_state            = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_SEC;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
        r_dvd   <= n_dvd;
        r_rem   <= n_rem;
        r_sec   <= n_sec;
        r_min   <= n_min;
        r_hr    <= n_hr;
        r_days  <= n_days;
        r_year  <= n_year;
        r_m100  <= n_m100;
        r_m400  <= n_m400;
        r_month <= n_month;
        r_out   <= n_out;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

endmodule

// ----- sv/epoch_seconds_to_calendar_date_top.sv -----
// steps per item: load, three 33-step divisions, up to 137 year steps,
// up to 12 month steps, then the result is registered once the output is free
// throughput: one item at a time, set by the single shared subtract unit
// a finished result waits in its output register while the next item runs
// reset: synchronous active low, clears control state and sets offset to 0
`timescale 1ns / 1ps

module epoch_seconds_to_calendar_date_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    e2c_in_if.sink      i_in,
    e2c_out_if.source   o_out,
    e2c_cfg_if.sink     i_cfg
);

    logic signed [e2c_pkg::OffW-1:0] r_offset;
    e2c_pkg::t_result                w_result;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
        end else if (i_cfg.valid) begin
            r_offset <= i_cfg.utc_offset_hours;
        end
    end

    e2c_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_epoch     (i_in.epoch_seconds),
        .i_offset    (r_offset),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_result    (w_result)
    );

    assign o_out.year_value   = w_result.year_value;
    assign o_out.month_value  = w_result.month_value;
    assign o_out.day_value    = w_result.day_value;
    assign o_out.hour_value   = w_result.hour_value;
    assign o_out.minute_value = w_result.minute_value;
    assign o_out.second_value = w_result.second_value;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input taken while an item is in work");

    a_date_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.month_value >= 4'd1 && o_out.month_value <= 4'd12 &&
                         o_out.day_value >= 5'd1 && o_out.year_value >= 12'd1970))
        else $error("date field out of range");

    a_time_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.hour_value < 5'd24 && o_out.minute_value < 6'd60 &&
                         o_out.second_value < 6'd60))
        else $error("time field out of range");

    a_new_result_from_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !$past(o_out.valid)) |-> !i_in.ready || $past(!i_in.ready))
        else $error("result appeared without an item in work");

endmodule
